/* rtl/isf_pkg.sv */
// Shared constants for the inverse-square source fit block.
// No dependencies; imported by inverse_square_source_fit_core.
`timescale 1ns / 1ps

package isf_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    localparam int POS_W  = 24;
    localparam int DOSE_W = 24;
    localparam int SMP_W  = 2 * POS_W + DOSE_W;
    localparam int WGT_W  = 57;     // 2^56 / r2, r2 >= 1
    localparam int INT_W  = 48;
    localparam int RES_W  = 63;

    localparam logic [INT_W-1:0] INT_MAX = '1;
    localparam logic [RES_W-1:0] RES_MAX = '1;

    localparam logic [1:0] OUT_OK   = 2'd0;
    localparam logic [1:0] OUT_NONE = 2'd1;
    localparam logic [1:0] OUT_ZERO = 2'd2;
    localparam logic [1:0] OUT_SAT  = 2'd3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

endpackage

/* rtl/isf_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module isf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/inverse_square_source_fit_core.sv */
// Inverse-square source fit: sample store, weight pass, intensity divide, residual pass.
// Depends on isf_pkg and isf_ram.
`timescale 1ns / 1ps

// A load item stores a sample (ignored once the store holds MAX_SAMPLES; first=1
// empties it beforehand). An evaluate item runs a zero-distance scan over the
// stored samples, then per sample a bit-serial reciprocal of 57 steps and four
// products on a 32x32 multiplier used in four partial steps each, then a 128-step
// bit-serial intensity divide, and a residual pass over the samples reusing the
// weights kept in a second RAM. One item is worked at a time; a finished result
// waits in the output register while the next item is taken.

module inverse_square_source_fit_core
    import isf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic                i_first,
    input  logic [POS_W-1:0]    i_pos_x,
    input  logic [POS_W-1:0]    i_pos_y,
    input  logic [DOSE_W-1:0]   i_dose_rate,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [INT_W-1:0]    o_intensity,
    output logic [RES_W-1:0]    o_residual_error,
    output logic [1:0]          o_outcome
);

    typedef enum logic [4:0] {
        S_IDLE, S_ZRD, S_ZCHK, S_WRD, S_WLAT, S_MUL, S_SQX, S_SQY, S_WDIV,
        S_WSTORE, S_WNUM, S_WDEN, S_WEND, S_IDIV, S_RRD, S_RLAT, S_RPRED,
        S_RRES, S_DONE
    } t_state;

    t_state r_state, r_ret;

    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_idx;
    logic [POS_W-1:0]  r_px, r_py;
    logic [24:0]       r_ay;
    logic [63:0]       r_r2;
    logic [WGT_W-1:0]  r_w;
    logic [63:0]       r_num, r_den, r_res;
    logic              r_sat, r_zero, r_psat;
    logic [INT_W-1:0]  r_inten;
    logic [INT_W-1:0]  r_fin_int;
    logic [RES_W-1:0]  r_fin_res;
    logic [1:0]        r_fin_oc;

    // multi-cycle 64x64 multiplier
    logic [63:0]  r_ma, r_mb, r_pp;
    logic [2:0]   r_mk;
    logic [1:0]   r_psh;
    logic [127:0] r_macc;

    // bit-serial divider
    logic [127:0] r_dvd;
    logic [63:0]  r_dsr, r_rem, r_q;
    logic [7:0]   r_dcnt;

    logic              r_ov;
    logic [INT_W-1:0]  r_o_int;
    logic [RES_W-1:0]  r_o_res;
    logic [1:0]        r_o_oc;

    // sample store access
    logic              in_acc, load_acc, smp_we;
    logic [CNT_W-1:0]  load_base;
    logic [IDX_W-1:0]  load_idx;
    logic [SMP_W-1:0]  smp_rd;
    logic [WGT_W-1:0]  wgt_rd;
    logic              idx_last;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign load_acc  = in_acc && (i_func == FUNC_LOAD);
    assign load_base = i_first ? '0 : r_count;
    assign smp_we    = load_acc && (load_base < CNT_W'(MAX_SAMPLES));
    assign load_idx  = IDX_W'(load_base);
    assign idx_last  = ((CNT_W+1)'(r_idx) + (CNT_W+1)'(1)) == (CNT_W+1)'(r_count);

    isf_ram #(.WIDTH(SMP_W), .DEPTH(MAX_SAMPLES)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (load_idx),
        .i_wdata ({i_pos_x, i_pos_y, i_dose_rate}),
        .i_raddr (r_idx),
        .o_rdata (smp_rd)
    );

    isf_ram #(.WIDTH(WGT_W), .DEPTH(MAX_SAMPLES)) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WSTORE),
        .i_waddr (r_idx),
        .i_wdata (r_q[WGT_W-1:0]),
        .i_raddr (r_idx),
        .o_rdata (wgt_rd)
    );

    logic [POS_W-1:0]  s_x, s_y;
    logic [DOSE_W-1:0] s_dose;
    logic [24:0]       dx, dy, ax, ay;
    assign {s_x, s_y, s_dose} = smp_rd;
    assign dx = {s_x[POS_W-1], s_x} - {r_px[POS_W-1], r_px};
    assign dy = {s_y[POS_W-1], s_y} - {r_py[POS_W-1], r_py};
    assign ax = dx[24] ? (~dx + 25'd1) : dx;
    assign ay = dy[24] ? (~dy + 25'd1) : dy;

    logic [31:0] m_a32, m_b32;
    logic [63:0] m_p;
    assign m_a32 = r_mk[0] ? r_ma[63:32] : r_ma[31:0];
    assign m_b32 = r_mk[1] ? r_mb[63:32] : r_mb[31:0];
    assign m_p   = m_a32 * m_b32;

    logic [127:0] pp_sh;
    always_comb begin
        case (r_psh)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd1:    pp_sh = {32'd0, r_pp, 32'd0};
            2'd2:    pp_sh = {r_pp, 64'd0};
            default: pp_sh = '0;
        endcase
    end

    logic [64:0] remsh, remsub;
    logic        d_ge;
    logic [63:0] qnx;
    assign remsh  = {r_rem, r_dvd[127]};
    assign d_ge   = remsh >= {1'b0, r_dsr};
    assign remsub = remsh - {1'b0, r_dsr};
    assign qnx    = {r_q[62:0], d_ge};

    // term and sum saturation for the weight pass
    logic        num_tsat, den_tsat;
    logic [63:0] num_t, den_t;
    logic [64:0] num_s, den_s;
    assign num_tsat = r_macc[127:80] != '0;
    assign num_t    = num_tsat ? '1 : r_macc[79:16];
    assign num_s    = {1'b0, r_num} + {1'b0, num_t};
    assign den_tsat = r_macc[127:88] != '0;
    assign den_t    = den_tsat ? '1 : r_macc[87:24];
    assign den_s    = {1'b0, r_den} + {1'b0, den_t};

    // prediction and residual
    logic        p_sat;
    logic [63:0] pred, err;
    logic [63:0] res_s;
    logic        res_bad;
    assign p_sat   = r_macc[127:104] != '0;
    assign pred    = p_sat ? '1 : r_macc[103:40];
    assign err     = (pred > 64'(s_dose)) ? pred - 64'(s_dose) : 64'(s_dose) - pred;
    assign res_bad = r_psat || (r_macc[127:63] != '0);
    assign res_s   = r_res + r_macc[63:0];

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_intensity      = r_o_int;
    assign o_residual_error = r_o_res;
    assign o_outcome        = r_o_oc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_count <= '0;
            r_num   <= '0;
            r_den   <= '0;
            r_ov    <= 1'b0;
            r_idx   <= '0;
            r_mk    <= '0;
            r_dcnt  <= '0;
        end else begin
            // S_DONE handles the output register itself
            if (r_ov && !i_out_stall && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (load_acc) begin
                        r_count <= smp_we ? load_base + CNT_W'(1) : load_base;
                    end else if (in_acc) begin
                        r_px   <= i_pos_x;
                        r_py   <= i_pos_y;
                        r_num  <= '0;
                        r_den  <= '0;
                        r_res  <= '0;
                        r_sat  <= 1'b0;
                        r_zero <= 1'b0;
                        r_idx  <= '0;
                        if (r_count == '0) begin
                            r_fin_int <= '0;
                            r_fin_res <= '0;
                            r_fin_oc  <= OUT_NONE;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_ZRD;
                        end
                    end
                end
                S_ZRD: r_state <= S_ZCHK;
                S_ZCHK: begin
                    if (idx_last) begin
                        r_idx <= '0;
                        if (r_zero || (ax == '0 && ay == '0)) begin
                            r_fin_int <= '0;
                            r_fin_res <= '0;
                            r_fin_oc  <= OUT_ZERO;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_WRD;
                        end
                    end else begin
                        if (ax == '0 && ay == '0) begin
                            r_zero <= 1'b1;
                        end
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_ZRD;
                    end
                end
                S_WRD: r_state <= S_WLAT;
                S_WLAT: begin
                    r_ay    <= ay;
                    r_ma    <= 64'(ax);
                    r_mb    <= 64'(ax);
                    r_mk    <= '0;
                    r_macc  <= '0;
                    r_ret   <= S_SQX;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mk != 3'd4) begin
                        r_pp  <= m_p;
                        r_psh <= 2'(r_mk[0]) + 2'(r_mk[1]);
                    end
                    if (r_mk != 3'd0) begin
                        r_macc <= r_macc + pp_sh;
                    end
                    if (r_mk == 3'd4) begin
                        r_state <= r_ret;
                    end else begin
                        r_mk <= r_mk + 3'd1;
                    end
                end
                S_SQX: begin
                    r_r2    <= r_macc[63:0];
                    r_ma    <= 64'(r_ay);
                    r_mb    <= 64'(r_ay);
                    r_mk    <= '0;
                    r_macc  <= '0;
                    r_ret   <= S_SQY;
                    r_state <= S_MUL;
                end
                S_SQY: begin
                    r_dsr   <= r_r2 + r_macc[63:0];
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_dvd   <= {1'b1, 127'd0};
                    r_dcnt  <= 8'(WGT_W);
                    r_state <= S_WDIV;
                end
                S_WDIV: begin
                    r_rem  <= d_ge ? remsub[63:0] : remsh[63:0];
                    r_q    <= qnx;
                    r_dvd  <= {r_dvd[126:0], 1'b0};
                    r_dcnt <= r_dcnt - 8'd1;
                    if (r_dcnt == 8'd1) begin
                        r_state <= S_WSTORE;
                    end
                end
                S_WSTORE: begin
                    r_w     <= r_q[WGT_W-1:0];
                    r_ma    <= 64'(s_dose);
                    r_mb    <= 64'(r_q[WGT_W-1:0]);
                    r_mk    <= '0;
                    r_macc  <= '0;
                    r_ret   <= S_WNUM;
                    r_state <= S_MUL;
                end
                S_WNUM: begin
                    r_num <= num_s[64] ? '1 : num_s[63:0];
                    if (num_tsat || num_s[64]) begin
                        r_sat <= 1'b1;
                    end
                    r_ma    <= 64'(r_w);
                    r_mb    <= 64'(r_w);
                    r_mk    <= '0;
                    r_macc  <= '0;
                    r_ret   <= S_WDEN;
                    r_state <= S_MUL;
                end
                S_WDEN: begin
                    r_den <= den_s[64] ? '1 : den_s[63:0];
                    if (den_tsat || den_s[64]) begin
                        r_sat <= 1'b1;
                    end
                    if (idx_last) begin
                        r_state <= S_WEND;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_WRD;
                    end
                end
                S_WEND: begin
                    if (r_den == '0) begin
                        r_fin_int <= INT_MAX;
                        r_fin_res <= RES_MAX;
                        r_fin_oc  <= OUT_SAT;
                        r_state   <= S_DONE;
                    end else begin
                        r_dsr   <= r_den;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_dvd   <= {32'd0, r_num, 32'd0};
                        r_dcnt  <= 8'd128;
                        r_state <= S_IDIV;
                    end
                end
                S_IDIV: begin
                    r_rem  <= d_ge ? remsub[63:0] : remsh[63:0];
                    r_q    <= qnx;
                    r_dvd  <= {r_dvd[126:0], 1'b0};
                    r_dcnt <= r_dcnt - 8'd1;
                    if (qnx[63:INT_W] != '0) begin
                        r_sat <= 1'b1;
                    end
                    if (r_dcnt == 8'd1) begin
                        r_inten <= (r_sat || qnx[63:INT_W] != '0) ? INT_MAX
                                                                  : qnx[INT_W-1:0];
                        r_idx   <= '0;
                        r_state <= S_RRD;
                    end
                end
                S_RRD: r_state <= S_RLAT;
                S_RLAT: begin
                    r_ma    <= 64'(r_inten);
                    r_mb    <= 64'(wgt_rd);
                    r_mk    <= '0;
                    r_macc  <= '0;
                    r_ret   <= S_RPRED;
                    r_state <= S_MUL;
                end
                S_RPRED: begin
                    r_psat  <= p_sat;
                    r_ma    <= err;
                    r_mb    <= err;
                    r_mk    <= '0;
                    r_macc  <= '0;
                    r_ret   <= S_RRES;
                    r_state <= S_MUL;
                end
                S_RRES: begin
                    if (res_bad || res_s > 64'(RES_MAX)) begin
                        r_sat <= 1'b1;
                        r_res <= 64'(RES_MAX);
                    end else begin
                        r_res <= res_s;
                    end
                    if (idx_last) begin
                        r_fin_int <= r_inten;
                        r_fin_res <= (res_bad || res_s > 64'(RES_MAX)) ? RES_MAX
                                                                       : res_s[RES_W-1:0];
                        r_fin_oc  <= (r_sat || res_bad || res_s > 64'(RES_MAX)) ? OUT_SAT
                                                                                : OUT_OK;
                        r_state   <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_RRD;
                    end
                end
                S_DONE: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov    <= 1'b1;
                        r_o_int <= r_fin_int;
                        r_o_res <= r_fin_res;
                        r_o_oc  <= r_fin_oc;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WDIV || r_state == S_IDIV) |-> r_dsr != '0)
        else $error("divide by zero in divider");

    a_none_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome == OUT_NONE || o_outcome == OUT_ZERO))
            |-> (o_intensity == '0 && o_residual_error == '0))
        else $error("non-zero payload with empty or zero-distance outcome");

    a_eval_needs_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ZCHK) |-> r_count != '0)
        else $error("sample scan with empty store");

endmodule
